[design/aus_pkg.sv]
// shared types and constants for the annex-b access unit splitter
`timescale 1ns / 1ps
`default_nettype none

package aus_pkg;

    // width of the internal byte offset counters
    localparam int OFFSET_BITS = 32;
    // width of the offsets carried on the result channel
    localparam int OUT_BITS    = 32;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // three-byte start code pattern and the idle value of the byte history
    localparam logic [23:0] START_CODE   = 24'h000001;
    localparam logic [23:0] HISTORY_IDLE = 24'hFFFFFF;

    // nal header type fields
    localparam logic [4:0] AVC_VCL_MIN  = 5'd1;
    localparam logic [4:0] AVC_VCL_MAX  = 5'd5;
    localparam logic [5:0] HEVC_VCL_MAX = 6'd31;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    // one input word
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
    } in_word_t;

    // one result word
    typedef struct packed {
        logic [OUT_BITS-1:0] unit_begin;
        logic [OUT_BITS-1:0] unit_end;
        logic                final_unit;
        logic                run_last;
    } out_word_t;

endpackage

`default_nettype wire

[design/annexb_access_unit_splitter_unit.sv]
// top level: annex-b start code scanner and access unit splitter
//
// Usage:
//   s_* channel takes one stream byte per word, with end_of_stream on the
//   last byte. m_* channel returns access units as begin/end byte offsets;
//   run_last marks the last result caused by one input byte.
//   cfg_wr_en / cfg_wr_data set hevc_mode (0 = h.264, 1 = h.265 headers);
//   write it only while the block is idle.
// Timing:
//   one byte is accepted every cycle. With the fifo empty, a byte's results
//   appear on m_* the cycle after it is accepted. A byte gives at most two
//   results (a split and the final unit on the same last byte), queued in a
//   four-entry result fifo; s_ready stays high while the fifo has room for
//   two words, so a stalled receiver backs up the input once three or four
//   words are buffered.
// Reset:
//   aresetn (synchronous, active low) clears the scanner state, empties the
//   result fifo and selects h.264 mode. After an end_of_stream byte the
//   scanner returns to its reset state on its own; hevc_mode is kept.
`timescale 1ns / 1ps
`default_nettype none

module annexb_access_unit_splitter_unit (
    input  wire                logic aclk,
    input  wire                logic aresetn,
    input  wire                logic cfg_wr_en,
    input  wire                logic cfg_wr_data,
    input  wire                logic s_valid,
    output                     logic s_ready,
    input  wire aus_pkg::in_word_t   s_data,
    output                     logic m_valid,
    input  wire                logic m_ready,
    output      aus_pkg::out_word_t  m_data
);

    import aus_pkg::*;

    // configuration
    logic hevc_mode_reg;

    // scanner state
    logic [23:0] recent_reg,    recent_next;
    offset_t     pos_reg,       pos_next;
    offset_t     cur_begin_reg, cur_begin_next;
    logic        has_vcl_reg,   has_vcl_next;
    logic        seen_reg,      seen_next;

    // result fifo
    out_word_t          fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;

    // per-byte decode
    logic        s_fire, m_fire;
    logic        is_header, vcl, split, final_emit;
    logic [23:0] shifted;
    offset_t     sc_pos, first_pos, pos_inc, begin_mid;
    out_word_t   split_word, final_word;
    logic [FIFO_CW-1:0] push_cnt;

    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign s_ready = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign m_valid = (count_reg != '0);
    assign m_data  = fifo_mem[rd_ptr_reg];

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hevc_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            hevc_mode_reg <= cfg_wr_data;
        end
    end

    // header classification and offset arithmetic
    always_comb begin
        is_header = (recent_reg == START_CODE);
        if (hevc_mode_reg) begin
            vcl = (s_data.stream_byte[6:1] <= HEVC_VCL_MAX);
        end else begin
            vcl = (s_data.stream_byte[4:0] >= AVC_VCL_MIN) &&
                  (s_data.stream_byte[4:0] <= AVC_VCL_MAX);
        end
        sc_pos    = (pos_reg > offset_t'(3)) ? pos_reg - offset_t'(3) : '0;
        first_pos = (pos_reg > offset_t'(2)) ? pos_reg - offset_t'(2) : '0;
        pos_inc   = (pos_reg == '1) ? pos_reg : pos_reg + offset_t'(1);
        shifted   = {recent_reg[15:0], s_data.stream_byte};
    end

    // next scanner state and results
    always_comb begin
        split     = is_header && vcl && has_vcl_reg;
        begin_mid = split ? sc_pos : cur_begin_reg;
        has_vcl_next = (is_header && vcl) ? 1'b1 : has_vcl_reg;
        if ((shifted == START_CODE) && !seen_reg) begin
            cur_begin_next = first_pos;
            seen_next      = 1'b1;
        end else begin
            cur_begin_next = begin_mid;
            seen_next      = seen_reg;
        end
        final_emit = s_data.end_of_stream && seen_next;

        split_word.unit_begin = OUT_BITS'(cur_begin_reg);
        split_word.unit_end   = OUT_BITS'(sc_pos);
        split_word.final_unit = 1'b0;
        split_word.run_last   = !final_emit;

        final_word.unit_begin = OUT_BITS'(cur_begin_next);
        final_word.unit_end   = OUT_BITS'(pos_inc);
        final_word.final_unit = 1'b1;
        final_word.run_last   = 1'b1;

        recent_next = shifted;
        pos_next    = pos_inc;
        if (s_data.end_of_stream) begin
            recent_next    = HISTORY_IDLE;
            pos_next       = '0;
            cur_begin_next = '0;
            has_vcl_next   = 1'b0;
            seen_next      = 1'b0;
        end
    end

    // scanner registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg    <= HISTORY_IDLE;
            pos_reg       <= '0;
            cur_begin_reg <= '0;
            has_vcl_reg   <= 1'b0;
            seen_reg      <= 1'b0;
        end else if (s_fire) begin
            recent_reg    <= recent_next;
            pos_reg       <= pos_next;
            cur_begin_reg <= cur_begin_next;
            has_vcl_reg   <= has_vcl_next;
            seen_reg      <= seen_next;
        end
    end

    // fifo occupancy
    always_comb begin
        push_cnt   = s_fire ? FIFO_CW'(split) + FIFO_CW'(final_emit) : '0;
        count_next = count_reg + push_cnt - FIFO_CW'(m_fire);
    end

    // fifo pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(m_fire);
            count_reg  <= count_next;
        end
    end

    // fifo storage: split word first, final word behind it
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (split) begin
                fifo_mem[wr_ptr_reg] <= split_word;
            end
            if (final_emit) begin
                fifo_mem[wr_ptr_reg + FIFO_AW'(split)] <= final_word;
            end
        end
    end

`ifndef SYNTHESIS
    // occupancy never passes the fifo depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result fifo overflow");

    // a word without run_last always has its partner queued behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.run_last) |-> (count_reg >= FIFO_CW'(2)))
        else $error("split word queued without its final word");

    // a closing unit is always the last word of its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.final_unit) |-> m_data.run_last)
        else $error("final unit without run_last");

    // units never run backwards
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.unit_begin <= m_data.unit_end))
        else $error("unit begin past unit end");
`endif

endmodule

`default_nettype wire
